### rtl/rgba_box_blur_core_assert.svh
// assertion macros of the rgba box blur rtl
// expects clk and rst_n in the scope of every use
`ifndef RGBA_BOX_BLUR_CORE_ASSERT_SVH
`define RGBA_BOX_BLUR_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define RBB_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// when ante holds, cons must follow
`define RBB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/rbb_pkg.sv
// shared types, constants and tables of the rgba box blur
// no dependencies
package rbb_pkg;

    localparam int RBB_MAX_KERNEL  = 15;
    localparam int RBB_MAX_WIDTH   = 2048;
    localparam int RBB_MAX_HEIGHT  = 4096;
    localparam int RBB_QUEUE_DEPTH = 4;

    // register indexes on the config port
    localparam logic [1:0] REG_KERNEL = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [3:0]  KERNEL_RESET = 4'd3;
    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    // ceil(2^24 / (k*k)); exact quotient for 8-bit samples as (x*m) >> 24
    localparam logic [24:0] RECIP [16] = '{
        25'd16777216, 25'd16777216, 25'd4194304, 25'd1864136,
        25'd1048576,  25'd671089,   25'd466034,  25'd342393,
        25'd262144,   25'd207127,   25'd167773,  25'd138655,
        25'd116509,   25'd99274,    25'd85599,   25'd74566
    };

    // one classified pixel handed from front to back
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [10:0] cx;
        logic [11:0] cy;
        logic [3:0]  k;
        logic [31:0] quot;
    } job_t;

    typedef struct packed {
        logic        window_valid;
        logic [10:0] center_x;
        logic [11:0] center_y;
        logic [7:0]  blur_red;
        logic [7:0]  blur_green;
        logic [7:0]  blur_blue;
        logic [7:0]  blur_alpha;
        logic        frame_end;
    } result_t;

endpackage

### rtl/rbb_pixel_if.sv
// pixel input channel of the rgba box blur
// no dependencies
interface rbb_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;

    modport source (output valid, output pixel_red, output pixel_green,
                    output pixel_blue, output pixel_alpha, input ready);
    modport sink (input valid, input pixel_red, input pixel_green,
                  input pixel_blue, input pixel_alpha, output ready);
endinterface

### rtl/rbb_result_if.sv
// result output channel of the rgba box blur
// no dependencies
interface rbb_result_if;
    logic        valid;
    logic        ready;
    logic        window_valid;
    logic [10:0] center_x;
    logic [11:0] center_y;
    logic [7:0]  blur_red;
    logic [7:0]  blur_green;
    logic [7:0]  blur_blue;
    logic [7:0]  blur_alpha;
    logic        frame_end;

    modport source (output valid, output window_valid, output center_x, output center_y,
                    output blur_red, output blur_green, output blur_blue,
                    output blur_alpha, output frame_end, input ready);
    modport sink (input valid, input window_valid, input center_x, input center_y,
                  input blur_red, input blur_green, input blur_blue,
                  input blur_alpha, input frame_end, output ready);
endinterface

### rtl/rbb_queue.sv
// small fifo between the front and back parts
// depends on rgba_box_blur_core_assert.svh
`include "rgba_box_blur_core_assert.svh"
module rbb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [NW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (32'(wr_reg) == DEPTH - 1) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (32'(rd_reg) == DEPTH - 1) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_reg];
    assign full     = (32'(count_reg) == DEPTH);
    assign empty    = (count_reg == '0);

    `RBB_ASSERT_IMPL(a_no_push_full, full, !push, "push into full queue")
    `RBB_ASSERT_IMPL(a_no_pop_empty, empty, !pop, "pop from empty queue")
    `RBB_ASSERT(a_count_bound, 32'(count_reg) <= DEPTH, "queue count out of range")
    `RBB_ASSERT_IMPL(a_push_lands, empty && push, ##1 !empty, "pushed word lost")
endmodule

### rtl/rbb_front.sv
// front part: accepts pixels, tracks raster position, classifies and divides
// depends on rbb_pkg and rbb_pixel_if
module rbb_front #(
    parameter int MAX_KERNEL = rbb_pkg::RBB_MAX_KERNEL,
    parameter int MAX_WIDTH  = rbb_pkg::RBB_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbb_pkg::RBB_MAX_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    rbb_pixel_if.sink                 pix,
    input  logic [3:0]                win_size,
    input  logic [11:0]               image_width,
    input  logic [12:0]               image_height,
    input  logic                      full,
    output logic                      push,
    output rbb_pkg::job_t             push_job,
    output logic [$clog2(MAX_WIDTH)-1:0]  push_col,
    output logic [$clog2(MAX_HEIGHT)-1:0] push_row,
    output logic [((MAX_KERNEL > 2) ? $clog2(MAX_KERNEL - 1) : 1)-1:0] push_slot
);
    import rbb_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SLOTS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int SLW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [SLW-1:0] slot_reg, slot_next;

    // stage register between accept and divide
    logic             stg_valid_reg, stg_valid_next;
    logic [3:0][7:0]  stg_px_reg;
    job_t             stg_job_reg;
    logic [CW-1:0]    stg_col_reg;
    logic [RW-1:0]    stg_row_reg;
    logic [SLW-1:0]   stg_slot_reg;

    logic [3:0]  k_eff;
    logic [CW:0] w_eff;
    logic [RW:0] h_eff;
    logic        accept, col_end, row_end, win_ok;
    logic [31:0] cx_full, cy_full;
    job_t        job_in;
    logic [32:0] prod [4];

    always_comb
    begin
        k_eff = (win_size == 4'd0) ? 4'd1 :
                (32'(win_size) > MAX_KERNEL) ? 4'(MAX_KERNEL) : win_size;
        w_eff = (image_width == 12'd0) ? (CW+1)'(1) :
                (32'(image_width) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(image_width);
        h_eff = (image_height == 13'd0) ? (RW+1)'(1) :
                (32'(image_height) > MAX_HEIGHT) ? (RW+1)'(MAX_HEIGHT)
                                                  : (RW+1)'(image_height);
        col_end = (32'(col_reg) + 32'd1 >= 32'(w_eff));
        row_end = (32'(row_reg) + 32'd1 >= 32'(h_eff));
        win_ok  = (32'(col_reg) + 32'd1 >= 32'(k_eff)) && (32'(row_reg) + 32'd1 >= 32'(k_eff));
        // top-left corner plus half the kernel
        cx_full = 32'(col_reg) + 32'd1 - 32'(k_eff) + 32'(k_eff >> 1);
        cy_full = 32'(row_reg) + 32'd1 - 32'(k_eff) + 32'(k_eff >> 1);

        job_in.valid = win_ok;
        job_in.last  = col_end && row_end;
        job_in.cx    = win_ok ? cx_full[10:0] : 11'd0;
        job_in.cy    = win_ok ? cy_full[11:0] : 12'd0;
        job_in.k     = k_eff;
        job_in.quot  = '0;
    end

    assign push      = stg_valid_reg && !full;
    assign pix.ready = !stg_valid_reg || !full;
    assign accept    = pix.valid && pix.ready;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (accept)
        begin
            if (col_end)
            begin
                col_next = '0;
                if (row_end)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    slot_next = (32'(slot_reg) == SLOTS - 1) ? '0 : slot_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        stg_valid_next = accept ? 1'b1 : (push ? 1'b0 : stg_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            slot_reg      <= slot_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_px_reg   <= {pix.pixel_alpha, pix.pixel_blue, pix.pixel_green, pix.pixel_red};
            stg_job_reg  <= job_in;
            stg_col_reg  <= col_reg;
            stg_row_reg  <= row_reg;
            stg_slot_reg <= slot_reg;
        end
    end

    // per-sample divide by k*k through the reciprocal table
    always_comb
    begin
        push_job = stg_job_reg;
        for (int c = 0; c < 4; c++)
        begin
            prod[c] = 33'(stg_px_reg[c]) * 33'(RECIP[stg_job_reg.k]);
            push_job.quot[8*c +: 8] = prod[c][31:24];
        end
    end

    assign push_col  = stg_col_reg;
    assign push_row  = stg_row_reg;
    assign push_slot = stg_slot_reg;
endmodule

### rtl/rbb_back.sv
// back part: line store, column sums, window sums and result register
// depends on rbb_pkg and rbb_result_if
module rbb_back #(
    parameter int MAX_KERNEL = rbb_pkg::RBB_MAX_KERNEL,
    parameter int MAX_WIDTH  = rbb_pkg::RBB_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbb_pkg::RBB_MAX_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  rbb_pkg::job_t             q_job,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0] q_row,
    input  logic [((MAX_KERNEL > 2) ? $clog2(MAX_KERNEL - 1) : 1)-1:0] q_slot,
    output logic                      q_pop,
    rbb_result_if.source              res
);
    import rbb_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SLOTS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int SLW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KIW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

    state_t          state_reg, state_next;
    job_t            job_reg, job_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [SLW-1:0]  here_reg, here_next;
    logic [SLW-1:0]  rslot_reg, rslot_next;
    logic [3:0]      d_reg, d_next;
    logic [15:0]     colsum_reg [4];
    logic [15:0]     colsum_next [4];
    logic [19:0]     acc_reg [4];
    logic [19:0]     acc_next [4];
    logic [63:0]     wc_reg [MAX_KERNEL];
    logic [63:0]     wc_next [MAX_KERNEL];
    logic            rd_valid_reg, rd_valid_next, rd_use_reg, rd_use_next;
    result_t         out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic [31:0]     store [SLOTS][MAX_WIDTH];
    logic [31:0]     rd_data_reg;
    logic            rd_en, mem_we;
    logic [20:0]     wsum [4];
    logic [7:0]      blur [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            wsum[c] = 21'(acc_reg[c]) + 21'(colsum_reg[c]);
            blur[c] = (wsum[c] > 21'd255) ? 8'd255 : wsum[c][7:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        here_next      = here_reg;
        rslot_next     = rslot_reg;
        d_next         = d_reg;
        colsum_next    = colsum_reg;
        acc_next       = acc_reg;
        wc_next        = wc_reg;
        rd_valid_next  = 1'b0;
        rd_use_next    = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        mem_we         = 1'b0;

        // fold in the previous-row quotient read last cycle
        if (rd_valid_reg && rd_use_reg)
        begin
            for (int c = 0; c < 4; c++)
            begin
                colsum_next[c] = colsum_reg[c] + 16'(rd_data_reg[8*c +: 8]);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    job_next  = q_job;
                    col_next  = q_col;
                    row_next  = q_row;
                    here_next = q_slot;
                    rslot_next = (q_slot == '0) ? SLW'(SLOTS - 1) : q_slot - 1'b1;
                    d_next    = 4'd1;
                    for (int c = 0; c < 4; c++)
                    begin
                        colsum_next[c] = 16'(q_job.quot[8*c +: 8]);
                        acc_next[c]    = '0;
                    end
                    state_next = (q_job.k > 4'd1) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                rd_use_next   = (32'(d_reg) <= 32'(row_reg));
                for (int c = 0; c < 4; c++)
                begin
                    acc_next[c] = acc_reg[c] + 20'(wc_reg[KIW'(d_reg - 4'd1)][16*c +: 16]);
                end
                d_next     = d_reg + 4'd1;
                rslot_next = (rslot_reg == '0) ? SLW'(SLOTS - 1) : rslot_reg - 1'b1;
                if (d_reg == job_reg.k - 4'd1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    mem_we = 1'b1;
                    for (int i = MAX_KERNEL - 1; i > 0; i--)
                    begin
                        wc_next[i] = wc_reg[i-1];
                    end
                    wc_next[0] = {colsum_reg[3], colsum_reg[2], colsum_reg[1], colsum_reg[0]};
                    out_next.window_valid = job_reg.valid;
                    out_next.center_x     = job_reg.cx;
                    out_next.center_y     = job_reg.cy;
                    out_next.blur_red     = job_reg.valid ? blur[0] : 8'd0;
                    out_next.blur_green   = job_reg.valid ? blur[1] : 8'd0;
                    out_next.blur_blue    = job_reg.valid ? blur[2] : 8'd0;
                    out_next.blur_alpha   = job_reg.valid ? blur[3] : 8'd0;
                    out_next.frame_end    = job_reg.last;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            rd_use_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_KERNEL; i++)
            begin
                wc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            rd_use_reg    <= rd_use_next;
            out_valid_reg <= out_valid_next;
            wc_reg        <= wc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        here_reg   <= here_next;
        rslot_reg  <= rslot_next;
        d_reg      <= d_next;
        colsum_reg <= colsum_next;
        acc_reg    <= acc_next;
        out_reg    <= out_next;
    end

    // line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[here_reg][col_reg] <= job_reg.quot;
        end
        if (rd_en)
        begin
            rd_data_reg <= store[rslot_reg][col_reg];
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.window_valid = out_reg.window_valid;
    assign res.center_x     = out_reg.center_x;
    assign res.center_y     = out_reg.center_y;
    assign res.blur_red     = out_reg.blur_red;
    assign res.blur_green   = out_reg.blur_green;
    assign res.blur_blue    = out_reg.blur_blue;
    assign res.blur_alpha   = out_reg.blur_alpha;
    assign res.frame_end    = out_reg.frame_end;
endmodule

### rtl/rgba_box_blur_core.sv
// rgba box blur: one pixel in, one result word out, k-by-k window average
// path: front stage register, queue, back iteration, then the result register
// flow: the back part reads the k-1 previous rows of the line store through its
//   single read port, while the queue lets the front keep taking pixels
// reset: rst_n clears position, window columns, queue and handshakes at once;
//   the line store is not cleared and is only read where it was written
module rgba_box_blur_core #(
    parameter int MAX_KERNEL = rbb_pkg::RBB_MAX_KERNEL,
    parameter int MAX_WIDTH  = rbb_pkg::RBB_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbb_pkg::RBB_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    rbb_pixel_if.sink   pix,
    rbb_result_if.source res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbb_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SLOTS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int SLW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int JW    = $bits(job_t);
    localparam int QW    = JW + CW + RW + SLW;

    // config registers; the user must write them only while the pipe is idle, not enforced here
    logic [3:0]  kernel_reg, kernel_next;
    logic [11:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic        wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite;

    always_comb
    begin
        kernel_next = kernel_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_hit)
        begin
            unique case (paddr[3:2])
                REG_KERNEL: kernel_next = pwdata[3:0];
                REG_WIDTH:  width_next  = pwdata[11:0];
                REG_HEIGHT: height_next = pwdata[12:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= KERNEL_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            kernel_reg <= kernel_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_KERNEL: prdata = {28'd0, kernel_reg};
            REG_WIDTH:  prdata = {20'd0, width_reg};
            REG_HEIGHT: prdata = {19'd0, height_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // front: position tracking, window classification, per-sample divide
    logic           push, full, pop, empty;
    job_t           push_job, q_job;
    logic [CW-1:0]  push_col, q_col;
    logic [RW-1:0]  push_row, q_row;
    logic [SLW-1:0] push_slot, q_slot;
    logic [QW-1:0]  q_in, q_out;

    rbb_front #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pix),
        .win_size     (kernel_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .full         (full),
        .push         (push),
        .push_job     (push_job),
        .push_col     (push_col),
        .push_row     (push_row),
        .push_slot    (push_slot)
    );

    // short queue lets the front keep taking pixels while the back iterates
    assign q_in = {push_job, push_col, push_row, push_slot};
    assign {q_job, q_col, q_row, q_slot} = q_out;

    rbb_queue #(
        .WIDTH (QW),
        .DEPTH (RBB_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (full),
        .pop       (pop),
        .pop_data  (q_out),
        .empty     (empty)
    );

    // back: line store reads, column and window sums, output register
    rbb_back #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (empty),
        .q_job   (q_job),
        .q_col   (q_col),
        .q_row   (q_row),
        .q_slot  (q_slot),
        .q_pop   (pop),
        .res     (res)
    );
endmodule

### tb/tb_rgba_box_blur_core.sv
// self-checking testbench of the rgba box blur core
// needs rbb_pkg, rbb_pixel_if, rbb_result_if and rgba_box_blur_core
module tb_rgba_box_blur_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rbb_pkg::*;

    localparam int LINE_ROWS  = RBB_MAX_KERNEL - 1;
    localparam int STALL_MAX  = 5000;
    localparam int DRAIN_WAIT = 24;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rbb_pixel_if  pix_if ();
    rbb_result_if res_if ();

    rgba_box_blur_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pixels waiting for the driver, blurred words waiting for the monitor
    pixel_t  pixel_q[$];
    result_t blur_q[$];

    // shadow of the block: registers, line store of quotients, column sums
    logic [3:0]  kernel_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [31:0] quot_store [LINE_ROWS * RBB_MAX_WIDTH];
    logic [63:0] col_sums   [RBB_MAX_KERNEL];
    int unsigned col_pos;
    int unsigned row_pos;

    int  src_idle_pct;
    int  snk_stall_pct;
    bit  src_hold;
    int  mismatches;
    int  stall_cycles;
    bit  apb_busy;

    initial begin
        clk = 1'b0;
    end
    always #4 clk = ~clk;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // advance the shadow by one pixel and return the word it must produce
    function automatic result_t blur_step(pixel_t px);
        int unsigned k;
        int unsigned w;
        int unsigned h;
        int unsigned div;
        int unsigned slot;
        int unsigned acc;
        int unsigned csum [4];
        logic [7:0]  chan [4];
        logic [31:0] packed_q;
        logic [31:0] prev;
        logic [63:0] col_word;
        result_t     r;
        k = clamp_to(kernel_reg, RBB_MAX_KERNEL);
        w = clamp_to(width_reg, RBB_MAX_WIDTH);
        h = clamp_to(height_reg, RBB_MAX_HEIGHT);
        div = k * k;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        chan[3] = px.alpha;
        packed_q = '0;
        for (int c = 0; c < 4; c++)
        begin
            csum[c] = chan[c] / div;
            packed_q[8*c +: 8] = csum[c][7:0];
        end
        // vertical sum over the k-1 rows above, where they exist
        for (int d = 1; d < k; d++)
        begin
            if (d <= row_pos)
            begin
                slot = ((row_pos % LINE_ROWS) + LINE_ROWS - d) % LINE_ROWS;
                prev = quot_store[slot * RBB_MAX_WIDTH + (col_pos % RBB_MAX_WIDTH)];
                for (int c = 0; c < 4; c++)
                    csum[c] += prev[8*c +: 8];
            end
        end
        quot_store[(row_pos % LINE_ROWS) * RBB_MAX_WIDTH + (col_pos % RBB_MAX_WIDTH)] = packed_q;
        col_word = '0;
        for (int c = 0; c < 4; c++)
            col_word[16*c +: 16] = csum[c][15:0];
        for (int i = RBB_MAX_KERNEL - 1; i > 0; i--)
            col_sums[i] = col_sums[i-1];
        col_sums[0] = col_word;

        r = '0;
        if ((col_pos + 1 >= k) && (row_pos + 1 >= k))
        begin
            r.window_valid = 1'b1;
            r.center_x = 11'(col_pos + 1 - k + k / 2);
            r.center_y = 12'(row_pos + 1 - k + k / 2);
            for (int c = 0; c < 4; c++)
            begin
                acc = 0;
                for (int i = 0; i < k; i++)
                    acc += col_sums[i][16*c +: 16];
                chan[c] = (acc > 255) ? 8'd255 : acc[7:0];
            end
            r.blur_red   = chan[0];
            r.blur_green = chan[1];
            r.blur_blue  = chan[2];
            r.blur_alpha = chan[3];
        end
        r.frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);

        // raster advance, wrapping when past a shrunk bound
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return r;
    endfunction

    // pixels still needed to bring the raster position back to the origin
    function automatic int frame_rest();
        int unsigned c;
        int unsigned r;
        int unsigned w;
        int unsigned h;
        int n;
        if (col_pos == 0 && row_pos == 0)
            return 0;
        w = clamp_to(width_reg, RBB_MAX_WIDTH);
        h = clamp_to(height_reg, RBB_MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        n = 0;
        do
        begin
            n++;
            if (c + 1 >= w)
            begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end
            else
                c++;
        end
        while (!(c == 0 && r == 0));
        return n;
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            p = '1;
        else if (sel == 1)
            p = '0;
        else
            p = pixel_t'($urandom);
        return p;
    endfunction

    // pixel driver: holds a word until accepted, then loads the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_if.valid       <= 1'b0;
            pix_if.pixel_red   <= '0;
            pix_if.pixel_green <= '0;
            pix_if.pixel_blue  <= '0;
            pix_if.pixel_alpha <= '0;
        end
        else
        begin
            if (pix_if.valid && pix_if.ready)
                blur_q.push_back(blur_step({pix_if.pixel_red, pix_if.pixel_green,
                                            pix_if.pixel_blue, pix_if.pixel_alpha}));
            if (!pix_if.valid || pix_if.ready)
            begin
                if (pixel_q.size() > 0 && !src_hold &&
                    $urandom_range(0, 99) >= src_idle_pct)
                begin
                    pix_if.valid       <= 1'b1;
                    pix_if.pixel_red   <= pixel_q[0].red;
                    pix_if.pixel_green <= pixel_q[0].green;
                    pix_if.pixel_blue  <= pixel_q[0].blue;
                    pix_if.pixel_alpha <= pixel_q[0].alpha;
                    void'(pixel_q.pop_front());
                end
                else
                    pix_if.valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got = {res_if.window_valid, res_if.center_x, res_if.center_y,
                       res_if.blur_red, res_if.blur_green, res_if.blur_blue,
                       res_if.blur_alpha, res_if.frame_end};
                if (blur_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: valid=%0d x=%0d y=%0d rgba=%h %h %h %h end=%0d",
                                 got.window_valid, got.center_x, got.center_y, got.blur_red,
                                 got.blur_green, got.blur_blue, got.blur_alpha, got.frame_end);
                end
                else
                begin
                    want = blur_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch exp: valid=%0d x=%0d y=%0d rgba=%h %h %h %h end=%0d",
                                     want.window_valid, want.center_x, want.center_y,
                                     want.blur_red, want.blur_green, want.blur_blue,
                                     want.blur_alpha, want.frame_end);
                            $display("         got: valid=%0d x=%0d y=%0d rgba=%h %h %h %h end=%0d",
                                     got.window_valid, got.center_x, got.center_y,
                                     got.blur_red, got.blur_green, got.blur_blue,
                                     got.blur_alpha, got.frame_end);
                        end
                    end
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if (!rst_n || apb_busy || (pix_if.valid && pix_if.ready) ||
            (res_if.valid && res_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // wait until every queued pixel went in and every word came out
    task automatic drain();
        while (pixel_q.size() > 0 || pix_if.valid || blur_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // setup then access write; the shadow register follows at the access edge
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        apb_busy <= 1'b1;
        psel     <= 1'b1;
        penable  <= 1'b0;
        pwrite   <= 1'b1;
        paddr    <= {idx, 2'b00};
        pwdata   <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_KERNEL: kernel_reg = value[3:0];
            REG_WIDTH:  width_reg  = value[11:0];
            default:    height_reg = value[12:0];
        endcase
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        apb_busy <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dims(int k, int w, int h);
        drain();
        reg_write(REG_KERNEL, k);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
    endtask

    task automatic push_pixels(int n);
        for (int i = 0; i < n; i++)
            pixel_q.push_back(rand_pixel());
    endtask

    task automatic push_frame();
        push_pixels(frame_rest() == 0 ?
                    clamp_to(width_reg, RBB_MAX_WIDTH) * clamp_to(height_reg, RBB_MAX_HEIGHT) :
                    frame_rest());
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
            default: begin src_idle_pct = 10; snk_stall_pct = 10; end
        endcase
    endtask

    initial begin
        int sent;
        int k;
        int w;
        int h;
        int frame;
        pixel_t p;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        apb_busy = 1'b0;
        src_hold = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        kernel_reg = KERNEL_RESET;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        col_pos = 0;
        row_pos = 0;
        foreach (quot_store[i])
            quot_store[i] = '0;
        foreach (col_sums[i])
            col_sums[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of every channel through a 3x3 window on a 4x4 image
        set_dims(3, 4, 4);
        for (int i = 0; i < 16; i++)
        begin
            p = (i % 3 == 0) ? '1 : (i % 3 == 1) ? '0 : pixel_t'(32'hff00_80_01);
            pixel_q.push_back(p);
        end
        // kernel of one and kernel register zero behave the same
        set_dims(1, 3, 2);
        push_frame();
        set_dims(0, 2, 2);
        push_frame();
        // kernel larger than the image: nothing ever valid
        set_dims(15, 5, 3);
        push_frame();
        // zero width and height act as one
        set_dims(2, 0, 0);
        push_frame();
        set_dims(2, 0, 3);
        push_frame();

        // width above the limit, then shrunk under the column position
        set_dims(15, 4095, 1);
        push_pixels(60);
        drain();
        reg_write(REG_WIDTH, 48);
        push_frame();
        // tallest image entered, then height shrunk under the row position
        set_dims(1, 1, 8191);
        push_pixels(10);
        drain();
        reg_write(REG_HEIGHT, 2);
        push_frame();
        set_dims(2, 3, 4096);
        push_pixels(12);
        drain();
        reg_write(REG_HEIGHT, 3);
        push_frame();
        // width shrunk under the column position in mid-frame
        set_dims(2, 8, 5);
        push_pixels(14);
        drain();
        reg_write(REG_WIDTH, 3);
        push_frame();
        // kernel changed in mid-frame: stored quotients keep old divisor
        set_dims(1, 6, 6);
        for (int i = 0; i < 18; i++)
            pixel_q.push_back('1);
        drain();
        reg_write(REG_KERNEL, 3);
        push_frame();
        set_dims(4, 6, 6);
        push_pixels(20);
        drain();
        reg_write(REG_KERNEL, 2);
        push_frame();

        // random frames, mostly small, under every idling pattern
        sent = 0;
        frame = 0;
        while (sent < 1400)
        begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 16);
            set_dims(k, w, h);
            set_idling(frame);
            push_frame();
            sent += w * h;
            frame++;
            // once, the sender waits for the block to empty before resuming
            if (frame == 5)
            begin
                push_pixels(0);
                src_hold = 1'b1;
                while (blur_q.size() > 0 || pix_if.valid)
                    @(posedge clk);
                src_hold = 1'b0;
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && blur_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/rbb_pkg.sv
rtl/rbb_pixel_if.sv
rtl/rbb_result_if.sv
rtl/rbb_queue.sv
rtl/rbb_front.sv
rtl/rbb_back.sv
rtl/rgba_box_blur_core.sv
tb/tb_rgba_box_blur_core.sv
